// ===== hdl/pl0_pkg.sv =====
// Shared types and constants for the P-code stack machine core.
package pl0_pkg;

    localparam int STACK_DEPTH    = 1024;
    localparam int CODE_DEPTH     = 1024;
    localparam int MAX_LEVEL_DIFF = 15;
    localparam int SA_W           = $clog2(STACK_DEPTH);
    localparam int PC_W           = $clog2(CODE_DEPTH);
    localparam int LVL_W          = 4;

    // opcodes
    localparam logic [3:0] OP_LIT  = 4'd0;
    localparam logic [3:0] OP_OPR  = 4'd1;
    localparam logic [3:0] OP_LOD  = 4'd2;
    localparam logic [3:0] OP_STO  = 4'd3;
    localparam logic [3:0] OP_CAL  = 4'd4;
    localparam logic [3:0] OP_INT  = 4'd5;
    localparam logic [3:0] OP_JMP  = 4'd6;
    localparam logic [3:0] OP_JPC  = 4'd7;
    localparam logic [3:0] OP_LEA  = 4'd8;
    localparam logic [3:0] OP_LODA = 4'd9;
    localparam logic [3:0] OP_STOA = 4'd10;

    // OPR sub-operations
    localparam logic [15:0] SUB_RET = 16'd0;
    localparam logic [15:0] SUB_NEG = 16'd1;
    localparam logic [15:0] SUB_ADD = 16'd2;
    localparam logic [15:0] SUB_SUB = 16'd3;
    localparam logic [15:0] SUB_MUL = 16'd4;
    localparam logic [15:0] SUB_DIV = 16'd5;
    localparam logic [15:0] SUB_ODD = 16'd6;
    localparam logic [15:0] SUB_EQU = 16'd7;
    localparam logic [15:0] SUB_NEQ = 16'd8;
    localparam logic [15:0] SUB_LES = 16'd9;
    localparam logic [15:0] SUB_GEQ = 16'd10;
    localparam logic [15:0] SUB_GTR = 16'd11;
    localparam logic [15:0] SUB_LEQ = 16'd12;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [3:0]  level_diff;
        logic [15:0] operand;
    } t_in_word;

    typedef struct packed {
        logic [9:0]         next_pc;
        logic               halted;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic [1:0]         error_code;
    } t_out_word;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_RD,     // read memory at cmd address into rd register
        CMD_WR,     // write cmd data at cmd address
        CMD_DIV     // start divider
    } t_dp_op;

    typedef struct packed {
        t_dp_op            op;
        logic [SA_W-1:0]   addr;
        logic [31:0]       wdata;
        logic [31:0]       div_a;
        logic [31:0]       div_b;
    } t_dp_cmd;

    typedef struct packed {
        logic [31:0] rdata;
        logic        div_done;
        logic [31:0] div_q;
    } t_dp_sts;

endpackage

// ===== hdl/pl0_datapath.sv =====
// Data stack memory and iterative signed divider.
module pl0_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pl0_pkg::t_dp_cmd i_cmd,
    output pl0_pkg::t_dp_sts o_sts
);

    localparam int CNT_W = 6;

    logic [31:0] r_mem [pl0_pkg::STACK_DEPTH];
    logic [31:0] r_rdata;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [31:0]       r_rem;
    logic [31:0]       r_quo;
    logic [31:0]       r_dvs;
    logic              r_qneg;
    logic [32:0]       n_trial;
    logic [31:0]       n_rem_sh;

    // memory port: one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pl0_pkg::CMD_WR) begin
            r_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[i_cmd.addr];
    end

    // restoring divide on magnitudes, one bit per cycle
    assign n_rem_sh = {r_rem[30:0], r_quo[31]};
    assign n_trial  = {1'b0, n_rem_sh} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.op == pl0_pkg::CMD_DIV) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_cmd.div_a[31] ? 32'd0 - i_cmd.div_a : i_cmd.div_a;
                r_dvs  <= i_cmd.div_b[31] ? 32'd0 - i_cmd.div_b : i_cmd.div_b;
                r_qneg <= i_cmd.div_a[31] ^ i_cmd.div_b[31];
            end else if (r_busy) begin
                if (n_trial[32]) begin
                    r_rem <= n_rem_sh;
                    r_quo <= {r_quo[30:0], 1'b0};
                end else begin
                    r_rem <= n_trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(31)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.rdata    = r_rdata;
    assign o_sts.div_done = r_done;
    assign o_sts.div_q    = r_qneg ? 32'd0 - r_quo : r_quo;

endmodule

// ===== hdl/pl0_control.sv =====
// Instruction sequencer: static link walk, operand fetch and write-back.
module pl0_control (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pl0_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output pl0_pkg::t_out_word o_data,
    output pl0_pkg::t_dp_cmd   o_cmd,
    input  pl0_pkg::t_dp_sts   i_sts
);

    localparam int SA = pl0_pkg::SA_W;
    localparam int PC = pl0_pkg::PC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_WALK, S_WALKW, S_RDA, S_RDAW, S_RDB, S_RDBW,
        S_EXEC, S_DIVW, S_WR1, S_WR2, S_WR3, S_DONE
    } t_state;

    t_state            r_state;
    logic [SA:0]       r_clr;
    pl0_pkg::t_in_word r_ins;
    logic [PC-1:0]     r_pc;
    logic [SA-1:0]     r_base;
    logic [SA-1:0]     r_top;
    logic [31:0]       r_bs;
    logic [3:0]        r_lvl;
    logic [31:0]       r_a;
    logic [31:0]       r_b;
    logic [31:0]       r_c;
    logic [31:0]       r_wd;
    pl0_pkg::t_out_word r_out;
    pl0_pkg::t_out_word r_res;
    logic              r_ov;
    pl0_pkg::t_dp_cmd  r_cmd;

    logic [PC-1:0]     n_pc1;
    logic [32:0]       n_bsum;
    logic signed [31:0] sa, sb;

    assign n_pc1 = r_pc + 1'b1;
    assign n_bsum = {1'b0, r_bs} + 33'(r_ins.operand);
    assign sa = r_a;
    assign sb = r_b;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_res;
    assign o_cmd   = r_cmd;

    function automatic pl0_pkg::t_dp_cmd mk(pl0_pkg::t_dp_op op, logic [SA-1:0] ad,
                                            logic [31:0] wd);
        pl0_pkg::t_dp_cmd c;
        c.op = op; c.addr = ad; c.wdata = wd; c.div_a = '0; c.div_b = '0;
        return c;
    endfunction

    function automatic logic fits(logic [31:0] v);
        return v < 32'(pl0_pkg::STACK_DEPTH);
    endfunction

    // finish: build result word from next pc, print value and error code
    function automatic pl0_pkg::t_out_word mkout(logic [PC-1:0] npc, logic pv,
                                                 logic [31:0] pval, logic [1:0] err);
        pl0_pkg::t_out_word w;
        w.next_pc = 10'(npc); w.halted = (npc == '0); w.print_valid = pv;
        w.print_value = pval; w.error_code = err;
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pc    <= '0;
            r_base  <= SA'(1);
            r_top   <= SA'(3);
            r_ov    <= 1'b0;
            r_cmd   <= mk(pl0_pkg::CMD_WR, '0, '0);
        end else begin
            r_cmd <= mk(pl0_pkg::CMD_NONE, '0, '0);
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    // zero the stack, one entry per cycle
                    if (r_clr == (SA+1)'(pl0_pkg::STACK_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                        r_cmd <= mk(pl0_pkg::CMD_WR, r_clr[SA-1:0] + 1'b1, '0);
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_ins   <= i_data;
                        r_bs    <= 32'(r_base);
                        // only frame-relative opcodes follow static links
                        if (i_data.opcode inside {pl0_pkg::OP_LOD, pl0_pkg::OP_STO,
                                                  pl0_pkg::OP_CAL, pl0_pkg::OP_LEA}) begin
                            r_lvl <= (i_data.level_diff > 4'(pl0_pkg::MAX_LEVEL_DIFF))
                                     ? 4'(pl0_pkg::MAX_LEVEL_DIFF) : i_data.level_diff;
                        end else begin
                            r_lvl <= '0;
                        end
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // follow static links
                    if (r_lvl == '0) begin
                        r_cmd   <= mk(pl0_pkg::CMD_RD, r_top, '0);
                        r_state <= S_RDAW;
                    end else if (!fits(r_bs)) begin
                        r_out   <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                        r_state <= S_DONE;
                    end else begin
                        r_cmd   <= mk(pl0_pkg::CMD_RD, r_bs[SA-1:0], '0);
                        r_state <= S_WALKW;
                    end
                end
                S_WALKW: r_state <= S_RDA;
                S_RDA: begin
                    r_bs    <= i_sts.rdata;
                    r_lvl   <= r_lvl - 1'b1;
                    r_state <= S_WALK;
                end
                S_RDAW: r_state <= S_RDB;
                S_RDB: begin
                    // r_a = stack[top]; second read depends on opcode
                    r_a <= i_sts.rdata;
                    unique case (r_ins.opcode)
                        pl0_pkg::OP_LOD:
                            r_cmd <= mk(pl0_pkg::CMD_RD, n_bsum[SA-1:0], '0);
                        pl0_pkg::OP_LODA:
                            r_cmd <= mk(pl0_pkg::CMD_RD, i_sts.rdata[SA-1:0], '0);
                        pl0_pkg::OP_OPR:
                            r_cmd <= mk(pl0_pkg::CMD_RD, r_top - 1'b1, '0);
                        default:
                            r_cmd <= mk(pl0_pkg::CMD_RD, r_top - 1'b1, '0);
                    endcase
                    r_state <= S_RDBW;
                end
                S_RDBW: begin
                    r_cmd   <= mk(pl0_pkg::CMD_RD, r_base + 1'b1, '0);
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    r_b     <= i_sts.rdata;
                    r_cmd   <= mk(pl0_pkg::CMD_RD, r_base + SA'(2), '0);
                    r_state <= S_WR2;
                end
                S_WR2: begin
                    r_c     <= i_sts.rdata;
                    r_state <= S_WR3;
                end
                S_WR3: begin
                    r_wd    <= i_sts.rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    // r_a=top, r_b=second read, r_c=stack[b+1], r_wd=stack[b+2]
                    r_state <= S_DONE;
                    r_out   <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_NONE);
                    r_pc    <= n_pc1;
                    unique case (r_ins.opcode)
                        pl0_pkg::OP_LIT: begin
                            if (r_top == SA'(pl0_pkg::STACK_DEPTH - 1)) begin
                                r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                            end else begin
                                r_top <= r_top + 1'b1;
                                r_cmd <= mk(pl0_pkg::CMD_WR, r_top + 1'b1,
                                            32'(r_ins.operand));
                            end
                        end
                        pl0_pkg::OP_OPR: begin
                            case (r_ins.operand)
                                pl0_pkg::SUB_RET: begin
                                    if (r_base == '0 ||
                                        32'(r_base) + 32'd2 >= 32'(pl0_pkg::STACK_DEPTH) ||
                                        !fits(r_c)) begin
                                        r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                                    end else begin
                                        r_pc   <= r_wd[PC-1:0];
                                        r_out  <= mkout(r_wd[PC-1:0], 1'b0, '0,
                                                        pl0_pkg::ERR_NONE);
                                        r_top  <= r_base - 1'b1;
                                        r_base <= r_c[SA-1:0];
                                    end
                                end
                                pl0_pkg::SUB_NEG:
                                    r_cmd <= mk(pl0_pkg::CMD_WR, r_top, 32'd0 - r_a);
                                pl0_pkg::SUB_ODD:
                                    r_cmd <= mk(pl0_pkg::CMD_WR, r_top,
                                                r_a[0] ? (r_a[31] ? 32'hFFFF_FFFF : 32'd1)
                                                       : 32'd0);
                                pl0_pkg::SUB_ADD, pl0_pkg::SUB_SUB, pl0_pkg::SUB_MUL,
                                pl0_pkg::SUB_DIV, pl0_pkg::SUB_EQU, pl0_pkg::SUB_NEQ,
                                pl0_pkg::SUB_LES, pl0_pkg::SUB_GEQ, pl0_pkg::SUB_GTR,
                                pl0_pkg::SUB_LEQ: begin
                                    if (r_top == '0) begin
                                        r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                                    end else begin
                                        r_top <= r_top - 1'b1;
                                        // x = r_b (second), y = r_a (top)
                                        case (r_ins.operand)
                                            pl0_pkg::SUB_ADD: r_cmd <= mk(pl0_pkg::CMD_WR,
                                                r_top - 1'b1, r_b + r_a);
                                            pl0_pkg::SUB_SUB: r_cmd <= mk(pl0_pkg::CMD_WR,
                                                r_top - 1'b1, r_b - r_a);
                                            pl0_pkg::SUB_MUL: r_cmd <= mk(pl0_pkg::CMD_WR,
                                                r_top - 1'b1, r_b * r_a);
                                            pl0_pkg::SUB_DIV: begin
                                                if (r_a == '0) begin
                                                    r_out <= mkout(n_pc1, 1'b0, '0,
                                                                   pl0_pkg::ERR_DIV0);
                                                end else begin
                                                    r_cmd.op    <= pl0_pkg::CMD_DIV;
                                                    r_cmd.div_a <= r_b;
                                                    r_cmd.div_b <= r_a;
                                                    r_state     <= S_DIVW;
                                                end
                                            end
                                            pl0_pkg::SUB_EQU: r_cmd <= mk(pl0_pkg::CMD_WR,
                                                r_top - 1'b1, 32'(sb == sa));
                                            pl0_pkg::SUB_NEQ: r_cmd <= mk(pl0_pkg::CMD_WR,
                                                r_top - 1'b1, 32'(sb != sa));
                                            pl0_pkg::SUB_LES: r_cmd <= mk(pl0_pkg::CMD_WR,
                                                r_top - 1'b1, 32'(sb < sa));
                                            pl0_pkg::SUB_GEQ: r_cmd <= mk(pl0_pkg::CMD_WR,
                                                r_top - 1'b1, 32'(sb >= sa));
                                            pl0_pkg::SUB_GTR: r_cmd <= mk(pl0_pkg::CMD_WR,
                                                r_top - 1'b1, 32'(sb > sa));
                                            default: r_cmd <= mk(pl0_pkg::CMD_WR,
                                                r_top - 1'b1, 32'(sb <= sa));
                                        endcase
                                    end
                                end
                                default: ;
                            endcase
                        end
                        pl0_pkg::OP_LOD: begin
                            if (n_bsum >= 33'(pl0_pkg::STACK_DEPTH) ||
                                r_top == SA'(pl0_pkg::STACK_DEPTH - 1)) begin
                                r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                            end else begin
                                r_top <= r_top + 1'b1;
                                r_cmd <= mk(pl0_pkg::CMD_WR, r_top + 1'b1, r_b);
                            end
                        end
                        pl0_pkg::OP_STO: begin
                            if (n_bsum >= 33'(pl0_pkg::STACK_DEPTH) || r_top == '0) begin
                                r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                            end else begin
                                r_top <= r_top - 1'b1;
                                r_cmd <= mk(pl0_pkg::CMD_WR, n_bsum[SA-1:0], r_a);
                                r_out <= mkout(n_pc1, 1'b1, r_a, pl0_pkg::ERR_NONE);
                            end
                        end
                        pl0_pkg::OP_CAL: begin
                            if (32'(r_top) + 32'd3 >= 32'(pl0_pkg::STACK_DEPTH)) begin
                                r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                            end else begin
                                // three writes: static link, dynamic link, return pc
                                r_cmd   <= mk(pl0_pkg::CMD_WR, r_top + 1'b1, r_bs);
                                r_a     <= 32'(r_base);
                                r_c     <= 32'(n_pc1);
                                r_base  <= r_top + 1'b1;
                                r_pc    <= r_ins.operand[PC-1:0];
                                r_out   <= mkout(r_ins.operand[PC-1:0], 1'b0, '0,
                                                 pl0_pkg::ERR_NONE);
                                r_lvl   <= 4'd2;
                                r_state <= S_DIVW;
                            end
                        end
                        pl0_pkg::OP_INT: begin
                            if (32'(r_top) + 32'(r_ins.operand) >=
                                32'(pl0_pkg::STACK_DEPTH)) begin
                                r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                            end else begin
                                r_top <= r_top + r_ins.operand[SA-1:0];
                            end
                        end
                        pl0_pkg::OP_JMP: begin
                            r_pc  <= r_ins.operand[PC-1:0];
                            r_out <= mkout(r_ins.operand[PC-1:0], 1'b0, '0,
                                           pl0_pkg::ERR_NONE);
                        end
                        pl0_pkg::OP_JPC: begin
                            if (r_top == '0) begin
                                r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                            end else begin
                                r_top <= r_top - 1'b1;
                                if (r_a == '0) begin
                                    r_pc  <= r_ins.operand[PC-1:0];
                                    r_out <= mkout(r_ins.operand[PC-1:0], 1'b0, '0,
                                                   pl0_pkg::ERR_NONE);
                                end
                            end
                        end
                        pl0_pkg::OP_LEA: begin
                            if (r_top == SA'(pl0_pkg::STACK_DEPTH - 1)) begin
                                r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                            end else begin
                                r_top <= r_top + 1'b1;
                                r_cmd <= mk(pl0_pkg::CMD_WR, r_top + 1'b1, n_bsum[31:0]);
                            end
                        end
                        pl0_pkg::OP_LODA: begin
                            if (!fits(r_a)) begin
                                r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                            end else begin
                                r_cmd <= mk(pl0_pkg::CMD_WR, r_top, r_b);
                            end
                        end
                        pl0_pkg::OP_STOA: begin
                            if (r_top == '0 || !fits(r_b)) begin
                                r_out <= mkout(n_pc1, 1'b0, '0, pl0_pkg::ERR_RANGE);
                            end else begin
                                r_cmd <= mk(pl0_pkg::CMD_WR, r_b[SA-1:0], r_a);
                                r_out <= mkout(n_pc1, 1'b1, r_a, pl0_pkg::ERR_NONE);
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIVW: begin
                    // wait for divider, or finish call frame writes
                    if (r_ins.opcode == pl0_pkg::OP_CAL) begin
                        if (r_lvl == 4'd2) begin
                            r_cmd <= mk(pl0_pkg::CMD_WR, r_base + 1'b1, r_a);
                            r_lvl <= 4'd1;
                        end else begin
                            r_cmd   <= mk(pl0_pkg::CMD_WR, r_base + SA'(2), r_c);
                            r_state <= S_DONE;
                        end
                    end else if (i_sts.div_done) begin
                        r_cmd   <= mk(pl0_pkg::CMD_WR, r_top, i_sts.div_q);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand the word to the output register once it is free
                    if (!r_ov || i_ready) begin
                        r_ov    <= 1'b1;
                        r_res   <= r_out;
                        r_pc    <= PC'(r_out.next_pc);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/pl0_stack_machine_core.sv =====
// Top level of the P-code stack machine core.
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in_data) takes one instruction word:
//   opcode, level difference and operand. Output channel
//   (o_out_valid/i_out_ready/o_out_data) returns one result word per
//   instruction: next pc, halt flag, printed value and error code.
// Sequence: each accepted word follows one static link per level difference
//   (LOD, STO, CAL and LEA only), then reads its operands and executes; a CAL
//   adds its frame writes and an OPR divide waits for the bit-serial divider.
// Acceptance: the next word is accepted from the cycle in which the result
//   word is registered, so instructions are taken one at a time; the
//   single-port stack memory sets the read sequence.
// Reset: i_rst_n low sets pc 0, base 1, top 3; after release a clearing pass
//   zeroes the stack, one entry per cycle, during which o_in_ready stays low.
// Stall: a result word is held in the output register until taken; the next
//   instruction executes meanwhile and waits in its last step until the
//   output register is free.
module pl0_stack_machine_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pl0_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pl0_pkg::t_out_word o_out_data
);

    pl0_pkg::t_dp_cmd w_cmd;
    pl0_pkg::t_dp_sts w_sts;

    // sequencer
    pl0_control u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // stack memory and divider
    pl0_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule

// ===== hdl/pl0_checker.sv =====
// Port-level checker for the stack machine core, bound to the top level.
module pl0_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pl0_pkg::t_out_word o_out_data
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // halt flag matches pc
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.halted == (o_out_data.next_pc == 10'd0)))
        else $error("halt flag mismatch");

    // drop ready after taking a word
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held after accepting a word");

    // printing never coexists with an error
    a_print_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.print_valid |->
            o_out_data.error_code == pl0_pkg::ERR_NONE)
        else $error("print with error");

endmodule

bind pl0_stack_machine_core pl0_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
